[sv/kt2_pkg.sv]
// ----------------------------------------------------------------------------
// kt2_pkg
// Shared types, fixed-point constants and helpers for the 2-D
// constant-acceleration tracker.
// ----------------------------------------------------------------------------
package kt2_pkg;

   localparam int FX_W  = 32;
   localparam int ACC_W = 52;   // sum of six rounded products plus an offset
   localparam int DET_W = 49;   // difference of two rounded products
   localparam int DIV_BITS = 48;

   typedef logic signed [FX_W-1:0]  fx_type;
   typedef logic signed [ACC_W-1:0] acc_type;
   typedef logic signed [DET_W-1:0] det_type;

   // Q16.16 constants at DT = 0.1
   localparam fx_type FX_ONE  = 32'sd65536;
   localparam fx_type FX_DT   = 32'sd6554;
   localparam fx_type FX_DT2  = 32'sd655;
   localparam fx_type FX_HDT2 = 32'sd328;
   localparam fx_type FX_HDT3 = 32'sd33;
   localparam fx_type FX_QDT4 = 32'sd2;
   localparam fx_type FX_MAX  = 32'sh7fffffff;
   localparam fx_type FX_MIN  = 32'sh80000000;

   localparam logic [2:0] POS_X = 3'd0;
   localparam logic [2:0] POS_Y = 3'd3;

   // request action codes
   localparam logic ACT_START  = 1'b0;
   localparam logic ACT_UPDATE = 1'b1;

   // register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_MEAS_NOISE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_COV   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_ACCEL = 2'd2;

   localparam logic [30:0] RESET_MEAS_NOISE = 31'd13107;
   localparam logic [30:0] RESET_INIT_COV   = 31'd32768000;
   localparam fx_type      RESET_INIT_ACCEL = 32'sd6554;

   // matrix store: {region, row, col}
   localparam int RAM_DEPTH = 192;
   localparam int RAM_AW    = 8;
   localparam logic [1:0] REG_P  = 2'd0;   // covariance
   localparam logic [1:0] REG_T  = 2'd1;   // F * P
   localparam logic [1:0] REG_PP = 2'd2;   // predicted covariance

   typedef struct packed {
      logic valid;
      logic first;
      logic last;
      logic sub;
   } mac_ctl_type;

   function automatic fx_type sat32(input acc_type v);
      fx_type r;
      if (v > acc_type'(FX_MAX))      r = FX_MAX;
      else if (v < acc_type'(FX_MIN)) r = FX_MIN;
      else                            r = v[FX_W-1:0];
      return r;
   endfunction

   // state transition matrix entry
   function automatic fx_type fx_trans(input logic [2:0] r, input logic [2:0] c);
      logic [2:0] rr;
      logic [2:0] cc;
      fx_type     v;
      rr = (r >= 3'd3) ? r - 3'd3 : r;
      cc = (c >= 3'd3) ? c - 3'd3 : c;
      v  = '0;
      if ((r >= 3'd3) == (c >= 3'd3)) begin
         if (cc == rr)             v = FX_ONE;
         else if (cc == rr + 3'd1) v = FX_DT;
         else if (cc == rr + 3'd2) v = FX_HDT2;
      end
      return v;
   endfunction

   // process noise entry
   function automatic fx_type fx_proc(input logic [2:0] r, input logic [2:0] c);
      logic [2:0] rr;
      logic [2:0] cc;
      logic [2:0] lo;
      logic [2:0] hi;
      fx_type     v;
      rr = (r >= 3'd3) ? r - 3'd3 : r;
      cc = (c >= 3'd3) ? c - 3'd3 : c;
      lo = (rr < cc) ? rr : cc;
      hi = (rr < cc) ? cc : rr;
      v  = '0;
      if ((r >= 3'd3) == (c >= 3'd3)) begin
         case ({lo[1:0], hi[1:0]})
            4'b0000: v = FX_QDT4;
            4'b0001: v = FX_HDT3;
            4'b0010: v = FX_HDT2;
            4'b0101: v = FX_DT2;
            4'b0110: v = FX_DT;
            4'b1010: v = FX_ONE;
            default: v = '0;
         endcase
      end
      return v;
   endfunction

endpackage

[sv/kt2_if.sv]
// ----------------------------------------------------------------------------
// kt2 channels
// Valid/ready request and response channels of the tracker.
// ----------------------------------------------------------------------------
interface kt2_req_if;
   import kt2_pkg::*;
   logic   valid;
   logic   ready;
   logic   action;
   fx_type meas_x;
   fx_type meas_y;

   modport source (output valid, action, meas_x, meas_y, input ready);
   modport sink   (input valid, action, meas_x, meas_y, output ready);
endinterface

interface kt2_rsp_if;
   import kt2_pkg::*;
   logic   valid;
   logic   ready;
   fx_type est_x;
   fx_type est_vx;
   fx_type est_ax;
   fx_type est_y;
   fx_type est_vy;
   fx_type est_ay;

   modport source (output valid, est_x, est_vx, est_ax, est_y, est_vy, est_ay,
                   input ready);
   modport sink   (input valid, est_x, est_vx, est_ax, est_y, est_vy, est_ay,
                   output ready);
endinterface

[sv/kalman_tracker_2d_const_accel.sv]
// ----------------------------------------------------------------------------
// kalman_tracker_2d_const_accel
// Six-state constant-acceleration Kalman filter for a 2-D pointer, Q16.16.
// ----------------------------------------------------------------------------
// A start request (action 0) loads position from the measurement, zero
// velocity, init_accel on both axes and init_cov * I; its response goes
// through the done state into the response register. An update request
// (action 1) runs a full predict/correct step: 728 multiply-accumulate
// terms pass one per cycle through the single 32x32 multiplier (dense 6x6
// products for F*P, (F*P)*F^T and (I-KH)*Pp dominate), pipeline drains
// separate the nine phases, and the four entries of S^-1 come from a
// 48-step restoring divider (skipped when det(S) is zero). One request is
// in work at a time; req_chan.ready is high only while idle. The response
// sits in an output register, so a new request can be taken while the
// previous response waits. The covariance, F*P and predicted covariance live
// in one RAM; after reset and after a start the covariance reads as a
// diagonal held in a register, so no clearing pass is needed. Registers
// are written through csr_we/csr_index/csr_wdata; the user must do so only
// while the block is idle, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
module kalman_tracker_2d_const_accel
   import kt2_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   kt2_req_if.sink              req_chan,
   kt2_rsp_if.source            rsp_chan,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_MAC, ST_DRAIN, ST_DIV, ST_DIV_WAIT, ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      PH_XP, PH_T, PH_PP, PH_S, PH_DET, PH_GAIN, PH_INNOV, PH_STATE, PH_COV
   } phase_type;

   typedef struct packed {
      phase_type  phase;
      logic [2:0] row;
      logic [2:0] col;
   } tag_type;

   // sequencer
   state_type  state_ff, state_in;
   phase_type  phase_ff, phase_in;
   logic [2:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [1:0] drain_ff, drain_in;
   logic [2:0] i_last, j_last, k_last;

   // config
   logic [30:0] meas_noise_ff, meas_noise_in;
   logic [30:0] init_cov_ff, init_cov_in;
   fx_type      init_accel_ff, init_accel_in;

   // filter state and scratch
   fx_type  x_ff [6];
   fx_type  x_in [6];
   fx_type  xp_ff [6];
   fx_type  xp_in [6];
   fx_type  gain_ff [6][2];
   fx_type  gain_in [6][2];
   fx_type  s_ff [4];
   fx_type  s_in [4];
   fx_type  inv_ff [4];
   fx_type  inv_in [4];
   fx_type  y_ff [2];
   fx_type  y_in [2];
   det_type det_ff, det_in;
   fx_type  mx_ff, mx_in, my_ff, my_in;
   logic    cov_diag_ff, cov_diag_in;   // covariance reads as diag_ff * I
   fx_type  diag_ff, diag_in;

   // response register
   logic   rsp_valid_ff, rsp_valid_in;
   fx_type est_ff [6];
   fx_type est_in [6];

   // issue stage
   mac_ctl_type s0_ctl;
   fx_type      s0_a, s0_b, s0_init;
   logic        s0_use_ram;
   logic [RAM_AW-1:0] ram_raddr;
   tag_type     s0_tag;
   logic signed [33:0] m_wide;

   // operand stage
   mac_ctl_type s1_ctl_ff;
   fx_type      s1_a_ff, s1_b_ff, s1_init_ff;
   logic        s1_use_ram_ff;
   tag_type     s1_tag_ff, s2_tag_ff;

   // shared units
   logic [31:0]       ram_rdata;
   logic              ram_we;
   logic [RAM_AW-1:0] ram_waddr;
   fx_type            mac_b;
   logic              mac_res_valid;
   acc_type           mac_res_wide;
   fx_type            mac_res_sat;
   logic              div_start;
   logic signed [32:0] div_num;
   logic              div_done;
   fx_type            div_quot;

   assign req_chan.ready = (state_ff == ST_IDLE);

   // loop bounds of each phase: rows, columns, terms
   always_comb begin
      case (phase_ff)
         PH_XP:    begin i_last = 3'd5; j_last = 3'd0; k_last = 3'd5; end
         PH_T:     begin i_last = 3'd5; j_last = 3'd5; k_last = 3'd5; end
         PH_PP:    begin i_last = 3'd5; j_last = 3'd5; k_last = 3'd5; end
         PH_S:     begin i_last = 3'd3; j_last = 3'd0; k_last = 3'd0; end
         PH_DET:   begin i_last = 3'd0; j_last = 3'd0; k_last = 3'd1; end
         PH_GAIN:  begin i_last = 3'd5; j_last = 3'd1; k_last = 3'd1; end
         PH_INNOV: begin i_last = 3'd1; j_last = 3'd0; k_last = 3'd0; end
         PH_STATE: begin i_last = 3'd5; j_last = 3'd0; k_last = 3'd1; end
         PH_COV:   begin i_last = 3'd5; j_last = 3'd5; k_last = 3'd5; end
         default:  begin i_last = 3'd0; j_last = 3'd0; k_last = 3'd0; end
      endcase
   end

   // issue: pick the operands of term k of entry (i, j)
   always_comb begin
      s0_ctl       = '0;
      s0_ctl.valid = (state_ff == ST_MAC);
      s0_ctl.first = (k_ff == 3'd0);
      s0_ctl.last  = (k_ff == k_last);
      s0_a         = FX_ONE;
      s0_b         = '0;
      s0_init      = '0;
      s0_use_ram   = 1'b0;
      ram_raddr    = '0;
      s0_tag       = '{phase: phase_ff, row: i_ff, col: j_ff};
      m_wide       = '0;
      case (phase_ff)
         PH_XP: begin
            s0_a = fx_trans(i_ff, k_ff);
            s0_b = x_ff[k_ff];
         end
         PH_T: begin
            s0_a       = fx_trans(i_ff, k_ff);
            s0_use_ram = !cov_diag_ff;
            ram_raddr  = {REG_P, k_ff, j_ff};
            s0_b       = (k_ff == j_ff) ? diag_ff : '0;
         end
         PH_PP: begin
            s0_a       = fx_trans(j_ff, k_ff);
            s0_use_ram = 1'b1;
            ram_raddr  = {REG_T, i_ff, k_ff};
            s0_init    = fx_proc(i_ff, j_ff);
         end
         PH_S: begin
            // 0: S00, 1: S01, 2: S10, 3: S11
            s0_use_ram = 1'b1;
            ram_raddr  = {REG_PP, i_ff[1] ? POS_Y : POS_X, i_ff[0] ? POS_Y : POS_X};
            if (i_ff == 3'd0 || i_ff == 3'd3) s0_init = fx_type'({1'b0, meas_noise_ff});
         end
         PH_DET: begin
            s0_a       = (k_ff == 3'd0) ? s_ff[0] : s_ff[1];
            s0_b       = (k_ff == 3'd0) ? s_ff[3] : s_ff[2];
            s0_ctl.sub = (k_ff != 3'd0);
         end
         PH_GAIN: begin
            s0_a       = inv_ff[{k_ff[0], j_ff[0]}];
            s0_use_ram = 1'b1;
            ram_raddr  = {REG_PP, i_ff, k_ff[0] ? POS_Y : POS_X};
         end
         PH_INNOV: begin
            s0_b       = xp_ff[i_ff[0] ? POS_Y : POS_X];
            s0_ctl.sub = 1'b1;
            s0_init    = i_ff[0] ? my_ff : mx_ff;
         end
         PH_STATE: begin
            s0_a    = gain_ff[i_ff][k_ff[0]];
            s0_b    = y_ff[k_ff[0]];
            s0_init = xp_ff[i_ff];
         end
         PH_COV: begin
            // (I - K H) entry built on the fly from the gain
            m_wide = (i_ff == k_ff) ? 34'sd65536 : 34'sd0;
            if (k_ff == POS_X) m_wide = m_wide - 34'(gain_ff[i_ff][0]);
            if (k_ff == POS_Y) m_wide = m_wide - 34'(gain_ff[i_ff][1]);
            s0_a       = sat32(acc_type'(m_wide));
            s0_use_ram = 1'b1;
            ram_raddr  = {REG_PP, k_ff, j_ff};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
      end else begin
         s1_ctl_ff <= s0_ctl;
      end
      s1_a_ff       <= s0_a;
      s1_b_ff       <= s0_b;
      s1_init_ff    <= s0_init;
      s1_use_ram_ff <= s0_use_ram;
      s1_tag_ff     <= s0_tag;
      s2_tag_ff     <= s1_tag_ff;
   end

   assign mac_b = s1_use_ram_ff ? fx_type'(ram_rdata) : s1_b_ff;

   kt2_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .ctl       (s1_ctl_ff),
      .a         (s1_a_ff),
      .b         (mac_b),
      .init      (s1_init_ff),
      .res_valid (mac_res_valid),
      .res_wide  (mac_res_wide),
      .res_sat   (mac_res_sat)
   );

   kt2_ram #(.WIDTH(32), .DEPTH(RAM_DEPTH)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (mac_res_sat),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // numerators of the adjugate: S11, -S01, -S10, S00
   always_comb begin
      case (i_ff[1:0])
         2'd0:    div_num = 33'(s_ff[3]);
         2'd1:    div_num = -33'(s_ff[1]);
         2'd2:    div_num = -33'(s_ff[2]);
         default: div_num = 33'(s_ff[0]);
      endcase
   end

   assign div_start = (state_ff == ST_DIV);

   kt2_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (det_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   // sequencer, request intake, write-back and response
   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      k_in          = k_ff;
      drain_in      = drain_ff;
      meas_noise_in = meas_noise_ff;
      init_cov_in   = init_cov_ff;
      init_accel_in = init_accel_ff;
      x_in          = x_ff;
      xp_in         = xp_ff;
      gain_in       = gain_ff;
      s_in          = s_ff;
      inv_in        = inv_ff;
      y_in          = y_ff;
      det_in        = det_ff;
      mx_in         = mx_ff;
      my_in         = my_ff;
      cov_diag_in   = cov_diag_ff;
      diag_in       = diag_ff;
      rsp_valid_in  = rsp_valid_ff;
      est_in        = est_ff;
      ram_we        = 1'b0;
      ram_waddr     = '0;

      if (rsp_valid_ff && rsp_chan.ready) rsp_valid_in = 1'b0;

      if (csr_we) begin
         case (csr_index)
            CSR_MEAS_NOISE: meas_noise_in = csr_wdata[30:0];
            CSR_INIT_COV:   init_cov_in   = csr_wdata[30:0];
            CSR_INIT_ACCEL: init_accel_in = fx_type'(csr_wdata);
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               mx_in = req_chan.meas_x;
               my_in = req_chan.meas_y;
               if (req_chan.action == ACT_START) begin
                  x_in[0]     = req_chan.meas_x;
                  x_in[1]     = '0;
                  x_in[2]     = init_accel_ff;
                  x_in[3]     = req_chan.meas_y;
                  x_in[4]     = '0;
                  x_in[5]     = init_accel_ff;
                  cov_diag_in = 1'b1;
                  diag_in     = fx_type'({1'b0, init_cov_ff});
                  state_in    = ST_DONE;
               end else begin
                  phase_in = PH_XP;
                  i_in     = '0;
                  j_in     = '0;
                  k_in     = '0;
                  state_in = ST_MAC;
               end
            end
         end
         ST_MAC: begin
            if (k_ff == k_last) begin
               k_in = '0;
               if (j_ff == j_last) begin
                  j_in = '0;
                  if (i_ff == i_last) begin
                     i_in     = '0;
                     drain_in = 2'd2;
                     state_in = ST_DRAIN;
                  end else begin
                     i_in = i_ff + 3'd1;
                  end
               end else begin
                  j_in = j_ff + 3'd1;
               end
            end else begin
               k_in = k_ff + 3'd1;
            end
         end
         ST_DRAIN: begin
            // wait until the last result of the phase is written back
            if (drain_ff != 2'd0) begin
               drain_in = drain_ff - 2'd1;
            end else begin
               state_in = ST_MAC;
               case (phase_ff)
                  PH_XP:    phase_in = PH_T;
                  PH_T:     phase_in = PH_PP;
                  PH_PP:    phase_in = PH_S;
                  PH_S:     phase_in = PH_DET;
                  PH_DET: begin
                     phase_in = PH_GAIN;
                     if (det_ff == '0) begin
                        // singular innovation: zero inverse, zero gain
                        for (int n = 0; n < 4; n++) inv_in[n] = '0;
                     end else begin
                        state_in = ST_DIV;
                     end
                  end
                  PH_GAIN:  phase_in = PH_INNOV;
                  PH_INNOV: phase_in = PH_STATE;
                  PH_STATE: phase_in = PH_COV;
                  default: begin
                     cov_diag_in = 1'b0;
                     state_in    = ST_DONE;
                  end
               endcase
            end
         end
         ST_DIV: begin
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               inv_in[i_ff[1:0]] = div_quot;
               if (i_ff == 3'd3) begin
                  i_in     = '0;
                  state_in = ST_MAC;
               end else begin
                  i_in     = i_ff + 3'd1;
                  state_in = ST_DIV;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               est_in       = x_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // write-back of finished sums
      if (mac_res_valid) begin
         case (s2_tag_ff.phase)
            PH_XP:    xp_in[s2_tag_ff.row] = mac_res_sat;
            PH_T: begin
               ram_we    = 1'b1;
               ram_waddr = {REG_T, s2_tag_ff.row, s2_tag_ff.col};
            end
            PH_PP: begin
               ram_we    = 1'b1;
               ram_waddr = {REG_PP, s2_tag_ff.row, s2_tag_ff.col};
            end
            PH_S:     s_in[s2_tag_ff.row[1:0]] = mac_res_sat;
            PH_DET:   det_in = mac_res_wide[DET_W-1:0];
            PH_GAIN:  gain_in[s2_tag_ff.row][s2_tag_ff.col[0]] = mac_res_sat;
            PH_INNOV: y_in[s2_tag_ff.row[0]] = mac_res_sat;
            PH_STATE: x_in[s2_tag_ff.row] = mac_res_sat;
            PH_COV: begin
               ram_we    = 1'b1;
               ram_waddr = {REG_P, s2_tag_ff.row, s2_tag_ff.col};
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         phase_ff      <= PH_XP;
         i_ff          <= '0;
         j_ff          <= '0;
         k_ff          <= '0;
         drain_ff      <= '0;
         meas_noise_ff <= RESET_MEAS_NOISE;
         init_cov_ff   <= RESET_INIT_COV;
         init_accel_ff <= RESET_INIT_ACCEL;
         for (int n = 0; n < 6; n++) x_ff[n] <= '0;
         cov_diag_ff   <= 1'b1;
         diag_ff       <= fx_type'({1'b0, RESET_INIT_COV});
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         i_ff          <= i_in;
         j_ff          <= j_in;
         k_ff          <= k_in;
         drain_ff      <= drain_in;
         meas_noise_ff <= meas_noise_in;
         init_cov_ff   <= init_cov_in;
         init_accel_ff <= init_accel_in;
         x_ff          <= x_in;
         cov_diag_ff   <= cov_diag_in;
         diag_ff       <= diag_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      xp_ff   <= xp_in;
      gain_ff <= gain_in;
      s_ff    <= s_in;
      inv_ff  <= inv_in;
      y_ff    <= y_in;
      det_ff  <= det_in;
      mx_ff   <= mx_in;
      my_ff   <= my_in;
      est_ff  <= est_in;
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.est_x  = est_ff[0];
   assign rsp_chan.est_vx = est_ff[1];
   assign rsp_chan.est_ax = est_ff[2];
   assign rsp_chan.est_y  = est_ff[3];
   assign rsp_chan.est_vy = est_ff[4];
   assign rsp_chan.est_ay = est_ff[5];

`ifndef SYNTHESIS
   // the MAC pipeline is empty whenever the divider is in use
   a_div_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV || state_ff == ST_DIV_WAIT) |-> !s1_ctl_ff.valid && !mac_res_valid)
      else $error("MAC pipeline busy during division");

   // matrix store is written only by the tail of a MAC phase
   a_ram_write: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_MAC || state_ff == ST_DRAIN))
      else $error("matrix write outside a MAC phase");

   // a divider result arrives only while it is awaited
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV_WAIT)
      else $error("unexpected divider completion");

   // an accepted request makes the block busy
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("ready after accepting a request");
`endif

endmodule

[sv/kt2_ram.sv]
// ----------------------------------------------------------------------------
// kt2_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module kt2_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 192
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem_ff[waddr] <= wdata;
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[sv/kt2_mac.sv]
// ----------------------------------------------------------------------------
// kt2_mac
// Shared Q16.16 multiply-accumulate: registered product, round, accumulate.
// ----------------------------------------------------------------------------
module kt2_mac
   import kt2_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mac_ctl_type ctl,
   input  fx_type      a,
   input  fx_type      b,
   input  fx_type      init,
   output logic        res_valid,
   output acc_type     res_wide,
   output fx_type      res_sat
);

   mac_ctl_type               ctl_ff;
   logic signed [63:0]        prod_ff;
   fx_type                    init_ff;
   acc_type                   acc_ff;
   acc_type                   acc_in;
   logic signed [63:0]        rsum;
   acc_type                   term;

   always_comb begin
      rsum   = prod_ff + 64'sd32768;
      term   = acc_type'($signed(rsum[63:16]));   // round half up
      if (ctl_ff.sub) term = -term;
      acc_in = (ctl_ff.first ? acc_type'(init_ff) : acc_ff) + term;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl;
      end
      prod_ff <= a * b;
      init_ff <= init;
      if (ctl_ff.valid) acc_ff <= acc_in;
   end

   assign res_valid = ctl_ff.valid & ctl_ff.last;
   assign res_wide  = acc_in;
   assign res_sat   = sat32(acc_in);

endmodule

[sv/kt2_div.sv]
// ----------------------------------------------------------------------------
// kt2_div
// Radix-2 restoring divider: sat32(trunc(num * 65536 / den)).
// ----------------------------------------------------------------------------
module kt2_div
   import kt2_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [32:0] num,
   input  det_type            den,
   output logic               done,
   output fx_type             quot
);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [5:0]              cnt_ff, cnt_in;
   logic                    neg_ff, neg_in;
   logic [DIV_BITS-1:0]     quo_ff, quo_in;
   logic [DIV_BITS-1:0]     rem_ff, rem_in;
   logic [DIV_BITS-1:0]     dmag_ff, dmag_in;
   logic signed [32:0]      nabs;
   det_type                 dabs;
   logic [DIV_BITS:0]       rem_sh;
   logic [DIV_BITS:0]       rem_sub;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dmag_in = dmag_ff;
      nabs    = num[32] ? -num : num;
      dabs    = den[DET_W-1] ? -den : den;
      rem_sh  = {rem_ff, quo_ff[DIV_BITS-1]};
      rem_sub = rem_sh - {1'b0, dmag_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         neg_in  = num[32] ^ den[DET_W-1];
         quo_in  = {nabs[31:0], 16'd0};
         rem_in  = '0;
         dmag_in = dabs[DIV_BITS-1:0];
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, dmag_ff}) begin
            rem_in = rem_sub[DIV_BITS-1:0];
            quo_in = {quo_ff[DIV_BITS-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DIV_BITS-1:0];
            quo_in = {quo_ff[DIV_BITS-2:0], 1'b0};
         end
         if (cnt_ff == 6'(DIV_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + 6'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      neg_ff  <= neg_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dmag_ff <= dmag_in;
   end

   always_comb begin
      if (neg_ff) begin
         if (quo_ff > DIV_BITS'(33'h080000000)) quot = FX_MIN;
         else                                   quot = -fx_type'(quo_ff[31:0]);
      end else begin
         if (quo_ff > DIV_BITS'(33'h07fffffff)) quot = FX_MAX;
         else                                   quot = fx_type'(quo_ff[31:0]);
      end
   end

   assign done = done_ff;

endmodule
